### sv/assert_macros.svh
// Assertion macros used by the checked module of the endpoint interpolator.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define BC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bc6h_ei_pkg.sv
// Package for the endpoint interpolator: weight tables, weight-set codes and types.
// No dependencies.
package bc6h_ei_pkg;

	localparam logic [1:0] WS_D3  = 2'd0;
	localparam logic [1:0] WS_D7  = 2'd1;
	localparam logic [1:0] WS_D15 = 2'd2;

	localparam logic [6:0] W7_TAB [8] = '{7'd0, 7'd9, 7'd18, 7'd27, 7'd37, 7'd46, 7'd55, 7'd64};
	localparam logic [6:0] W15_TAB [16] = '{7'd0, 7'd4, 7'd9, 7'd13, 7'd17, 7'd21, 7'd26,
		7'd30, 7'd34, 7'd38, 7'd43, 7'd47, 7'd51, 7'd55, 7'd60, 7'd64};

	localparam logic [24:0] MIX_ROUND = 25'd32;
	localparam logic [4:0]  SCALE_31  = 5'd31;
	localparam logic [15:0] HALF_SIGN = 16'h8000;
	localparam logic [15:0] HALF_UMAX = 16'h7BFF;

	typedef struct packed {
		logic [6:0] wa;
		logic [6:0] wb;
	} wpair_t;

	function automatic wpair_t pick_weights(input logic [3:0] idx, input logic [1:0] ws);
		wpair_t     w;
		logic [1:0] i3;
		logic [2:0] i7;
		logic [3:0] p;
		i3 = (idx > 4'd3) ? 2'd3 : idx[1:0];
		i7 = (idx > 4'd7) ? 3'd7 : idx[2:0];
		p  = 4'({2'b00, i3} * 4'd5);
		unique case (ws)
			WS_D3: begin
				w.wa = W15_TAB[4'd15 - p];
				w.wb = W15_TAB[p];
			end
			WS_D7: begin
				w.wa = W7_TAB[3'd7 - i7];
				w.wb = W7_TAB[i7];
			end
			default: begin
				w.wa = W15_TAB[4'd15 - idx];
				w.wb = W15_TAB[idx];
			end
		endcase
		return w;
	endfunction

endpackage

### sv/bc6h_endpoint_interpolate_top.sv
// Endpoint unquantize and interpolate for one texel channel, with its request pipeline.
// Depends on bc6h_ei_pkg, bc6h_ei_unquant and assert_macros.svh.
//
// A request passes four register stages (unquantize and weight selection, the two
// weight products, the rounded blend, the 31/64 or 31/32 scaling into the output
// register); one request is accepted every cycle unless the output stalls.
// Each stage advances whenever the stage after it is empty or moving, so a stalled
// output holds every request in place without loss.
// The format register must only be written while the pipeline is empty.
module bc6h_endpoint_interpolate_top import bc6h_ei_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [16:0] endpoint_a,
	input  logic signed [16:0] endpoint_b,
	input  logic        [4:0]  precision,
	input  logic        [3:0]  texel_index,
	input  logic        [1:0]  weight_set,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] texel_half_bits
);

`include "assert_macros.svh"

	logic signed_format_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic [4:0]         prec_c;
	logic signed [16:0] ua_c, ub_c;
	wpair_t             w_c;

	logic signed [16:0] ua_s1, ub_s1;
	wpair_t             w_s1;
	logic               sf_s1;

	logic signed [24:0] pa_s2, pb_s2;
	logic               sf_s2;

	logic signed [24:0] sum_c;
	logic signed [24:0] shf_c;
	logic signed [16:0] mix_c;
	logic [15:0]        mix_mag_c;
	logic [15:0]        mag_s3;
	logic               neg_s3;
	logic               sf_s3;

	logic [20:0] prod_c;
	logic [15:0] fin_c;
	logic [15:0] res_c;
	logic [15:0] res_s4;
	logic        sf_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_format_q <= 1'b0;
		end else if (cfg_we) begin
			signed_format_q <= cfg_wdata;
		end
	end

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign prec_c = (precision < 5'd2) ? 5'd2 : ((precision > 5'd16) ? 5'd16 : precision);
	assign w_c    = pick_weights(texel_index, weight_set);

	bc6h_ei_unquant u_unq_a (
		.q          (endpoint_a),
		.prec       (prec_c),
		.signed_fmt (signed_format_q),
		.value      (ua_c)
	);

	bc6h_ei_unquant u_unq_b (
		.q          (endpoint_b),
		.prec       (prec_c),
		.signed_fmt (signed_format_q),
		.value      (ub_c)
	);

	assign sum_c     = pa_s2 + pb_s2 + $signed(MIX_ROUND);
	assign shf_c     = sum_c >>> 6;
	assign mix_c     = shf_c[16:0];
	assign mix_mag_c = mix_c[16] ? 16'(17'd0 - $unsigned(mix_c)) : mix_c[15:0];

	assign prod_c = {5'd0, mag_s3} * {16'd0, SCALE_31};
	assign fin_c  = sf_s3 ? prod_c[20:5] : {1'b0, prod_c[20:6]};
	assign res_c  = (neg_s3 && fin_c != 16'd0) ? (HALF_SIGN | fin_c) : fin_c;

	always_ff @(posedge clk) begin
		if (en1) begin
			ua_s1 <= ua_c;
			ub_s1 <= ub_c;
			w_s1  <= w_c;
			sf_s1 <= signed_format_q;
		end
		if (en2) begin
			pa_s2 <= 25'($signed({{8{ua_s1[16]}}, ua_s1}) * $signed({18'd0, w_s1.wa}));
			pb_s2 <= 25'($signed({{8{ub_s1[16]}}, ub_s1}) * $signed({18'd0, w_s1.wb}));
			sf_s2 <= sf_s1;
		end
		if (en3) begin
			mag_s3 <= mix_mag_c;
			neg_s3 <= mix_c[16];
			sf_s3  <= sf_s2;
		end
		if (en4) begin
			res_s4 <= res_c;
			sf_s4  <= sf_s3;
		end
	end

	assign out_valid       = v_s4;
	assign texel_half_bits = res_s4;

	`BC_ASSERT_IMP(a_unsigned_range, v_s4 && !sf_s4, res_s4 <= HALF_UMAX, "unsigned half out of range")
	`BC_ASSERT_IMP(a_no_neg_zero, v_s4, res_s4 != HALF_SIGN, "negative zero produced")
	`BC_ASSERT_NXT(a_stall_hold, v_s2 && v_s3 && v_s4 && !out_ready, v_s2 && v_s3 && v_s4,
		"request lost during stall")

endmodule

### sv/bc6h_ei_unquant.sv
// Unquantizes one endpoint to the 16-bit range, unsigned or signed.
// Depends on bc6h_ei_pkg.
module bc6h_ei_unquant import bc6h_ei_pkg::*; (
	input  logic signed [16:0] q,
	input  logic        [4:0]  prec,
	input  logic               signed_fmt,
	output logic signed [16:0] value
);

	logic [15:0] qn;
	logic [15:0] top_u;
	logic [15:0] qc;
	logic [29:0] num_u;
	logic [15:0] val_u;
	logic [16:0] mag;
	logic [3:0]  sh_s;
	logic [14:0] thr_s;
	logic [28:0] num_s;
	logic [14:0] m_s;
	logic signed [16:0] val_s;

	always_comb begin
		qn    = q[16] ? 16'd0 : q[15:0];
		top_u = 16'((17'd1 << prec) - 17'd1);
		qc    = (qn > top_u) ? top_u : qn;
		num_u = {qc[13:0], 16'h8000} >> prec;
		if (prec >= 5'd15) begin
			val_u = qn;
		end else if (qc == 16'd0) begin
			val_u = 16'd0;
		end else if (qc == top_u) begin
			val_u = 16'hFFFF;
		end else begin
			val_u = num_u[15:0];
		end
	end

	always_comb begin
		mag   = q[16] ? (17'd0 - $unsigned(q)) : $unsigned(q);
		sh_s  = 4'(prec - 5'd1);
		thr_s = 15'((16'd1 << sh_s) - 16'd1);
		num_s = {mag[13:0], 15'h4000} >> sh_s;
		if (mag == 17'd0) begin
			m_s = 15'd0;
		end else if (mag >= {2'b00, thr_s}) begin
			m_s = 15'h7FFF;
		end else begin
			m_s = num_s[14:0];
		end
		if (prec == 5'd16) begin
			if (q > 17'sd32767) begin
				val_s = 17'sd32767;
			end else if (q < -17'sd32767) begin
				val_s = -17'sd32767;
			end else begin
				val_s = q;
			end
		end else if (q[16]) begin
			val_s = -$signed({2'b00, m_s});
		end else begin
			val_s = $signed({2'b00, m_s});
		end
	end

	assign value = signed_fmt ? val_s : $signed({1'b0, val_u});

endmodule

### verif/bc6h_endpoint_interpolate_checker.sv
// Checker for the BC6H endpoint interpolator: follows the format register, predicts the
// half pattern of each accepted request and compares it with the returned result.
// Depends on bc6h_ei_pkg for the weight-set codes and the half sign bit.
module bc6h_endpoint_interpolate_checker import bc6h_ei_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [16:0] endpoint_a,
	input  logic signed [16:0] endpoint_b,
	input  logic        [4:0]  precision,
	input  logic        [3:0]  texel_index,
	input  logic        [1:0]  weight_set,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic        [15:0] texel_half_bits,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint U16_TOP = 65535;
	localparam longint S16_TOP = 32767;
	localparam longint WEIGHT_8 [8] = '{0, 9, 18, 27, 37, 46, 55, 64};
	localparam longint WEIGHT_16 [16] = '{0, 4, 9, 13, 17, 21, 26, 30, 34, 38, 43, 47, 51,
		55, 60, 64};

	typedef struct {
		logic signed [16:0] qa;
		logic signed [16:0] qb;
		logic        [4:0]  prec;
		logic        [3:0]  idx;
		logic        [1:0]  ws;
		logic        [15:0] half;
	} texel_expect_t;

	texel_expect_t expected_texels [$];
	texel_expect_t head;
	texel_expect_t req;
	logic          signed_fmt;

	initial fail_count = 0;

	function automatic longint unquant_unsigned(input longint q, input int prec);
		longint top;
		top = (longint'(1) << prec) - 1;
		if (q < 0)
			q = 0;
		if (prec >= 15)
			return (q > U16_TOP) ? U16_TOP : q;
		if (q > top)
			q = top;
		if (q == 0)
			return 0;
		if (q == top)
			return U16_TOP;
		return (q * 65536 + 32768) >>> prec;
	endfunction

	function automatic longint unquant_signed(input longint q, input int prec);
		longint mag;
		longint u;
		if (prec >= 16)
			return (q > S16_TOP) ? S16_TOP : (q < -S16_TOP) ? -S16_TOP : q;
		mag = (q < 0) ? -q : q;
		if (mag == 0)
			return 0;
		if (mag >= (longint'(1) << (prec - 1)) - 1)
			u = S16_TOP;
		else
			u = (mag * 32768 + 16384) >>> (prec - 1);
		return (q < 0) ? -u : u;
	endfunction

	function automatic logic [15:0] predict_texel(input logic signed [16:0] qa,
		input logic signed [16:0] qb, input logic [4:0] prec_in, input logic [3:0] idx_in,
		input logic [1:0] ws, input logic fmt);
		int     prec;
		int     idx;
		longint ua;
		longint ub;
		longint wa;
		longint wb;
		longint mix;
		longint mag;
		prec = (prec_in < 2) ? 2 : (prec_in > 16) ? 16 : int'(prec_in);
		if (fmt) begin
			ua = unquant_signed(qa, prec);
			ub = unquant_signed(qb, prec);
		end else begin
			ua = unquant_unsigned(qa, prec);
			ub = unquant_unsigned(qb, prec);
		end
		case (ws)
			WS_D3: begin
				idx = (idx_in > 3) ? 3 : int'(idx_in);
				wa = WEIGHT_16[15 - idx * 5];
				wb = WEIGHT_16[idx * 5];
			end
			WS_D7: begin
				idx = (idx_in > 7) ? 7 : int'(idx_in);
				wa = WEIGHT_8[7 - idx];
				wb = WEIGHT_8[idx];
			end
			default: begin
				idx = int'(idx_in);
				wa = WEIGHT_16[15 - idx];
				wb = WEIGHT_16[idx];
			end
		endcase
		mix = (ua * wa + ub * wb + 32) >>> 6;
		if (!fmt)
			return 16'((mix * 31) >>> 6);
		if (mix >= 0)
			return 16'((mix * 31) >>> 5);
		mag = ((-mix) * 31) >>> 5;
		return (mag == 0) ? 16'h0000 : (HALF_SIGN | 16'(mag));
	endfunction

	task automatic report_mismatch(input string what, input texel_expect_t r,
		input logic [15:0] got);
		fail_count++;
		$display("%0t ns: %s: a=%0d b=%0d prec=%0d idx=%0d ws=%0d got %h expected %h",
			$time, what, r.qa, r.qb, r.prec, r.idx, r.ws, got, r.half);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_fmt <= 1'b0;
			expected_texels.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				req.qa = endpoint_a;
				req.qb = endpoint_b;
				req.prec = precision;
				req.idx = texel_index;
				req.ws = weight_set;
				req.half = predict_texel(endpoint_a, endpoint_b, precision, texel_index,
					weight_set, signed_fmt);
				expected_texels.push_back(req);
			end
			if (out_valid && out_ready) begin
				if (expected_texels.size() == 0) begin
					head = '{default: '0};
					report_mismatch("result with no request pending", head, texel_half_bits);
				end else begin
					head = expected_texels.pop_front();
					if (texel_half_bits !== head.half)
						report_mismatch("texel_half_bits mismatch", head, texel_half_bits);
				end
			end
			if (cfg_we)
				signed_fmt <= cfg_wdata;
			pending <= expected_texels.size();
		end
	end

endmodule

### verif/bc6h_endpoint_interpolate_top_tb.sv
// Testbench top for bc6h_endpoint_interpolate_top: drives directed and random requests
// under both half formats and three idling regimes, and gives the verdict.
// Depends on bc6h_ei_pkg, the block itself and bc6h_endpoint_interpolate_checker.
module bc6h_endpoint_interpolate_top_tb import bc6h_ei_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] WS_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_PER_PHASE = 125;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [16:0] endpoint_a = '0;
	logic signed [16:0] endpoint_b = '0;
	logic        [4:0]  precision = '0;
	logic        [3:0]  texel_index = '0;
	logic        [1:0]  weight_set = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [15:0] texel_half_bits;

	int   fail_count;
	int   pending;
	int   send_idle_pct = 38;
	int   recv_idle_pct = 68;
	int   cycle_count = 0;
	logic cur_format = 1'b0;

	always #1ns clk = ~clk;

	bc6h_endpoint_interpolate_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.endpoint_a(endpoint_a),
		.endpoint_b(endpoint_b),
		.precision(precision),
		.texel_index(texel_index),
		.weight_set(weight_set),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.texel_half_bits(texel_half_bits)
	);

	bc6h_endpoint_interpolate_checker texel_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.endpoint_a(endpoint_a),
		.endpoint_b(endpoint_b),
		.precision(precision),
		.texel_index(texel_index),
		.weight_set(weight_set),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.texel_half_bits(texel_half_bits),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_request(input logic signed [16:0] a, input logic signed [16:0] b,
		input logic [4:0] p, input logic [3:0] i, input logic [1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		endpoint_a <= a;
		endpoint_b <= b;
		precision <= p;
		texel_index <= i;
		weight_set <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_format(input logic fmt);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= fmt;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_format = fmt;
	endtask

	// Values valid in one format are deliberately out of range in the other.
	task automatic run_directed();
		send_request(17'sd0, 17'sd63, 5'd6, 4'd0, WS_D3);
		send_request(17'sd0, 17'sd63, 5'd6, 4'd15, WS_D3);
		send_request(17'sd65535, 17'sd0, 5'd16, 4'd15, WS_D7);
		send_request(-17'sd65536, 17'sd65535, 5'd16, 4'd5, WS_D15);
		send_request(-17'sd32767, 17'sd32767, 5'd16, 4'd15, WS_SPARE);
		send_request(17'sd40000, -17'sd5, 5'd15, 4'd8, WS_D15);
		send_request(17'sd2000, 17'sd1, 5'd10, 4'd2, WS_D7);
		send_request(17'sd1, 17'sd2, 5'd0, 4'd1, WS_D3);
		send_request(-17'sd1, 17'sd3, 5'd31, 4'd0, WS_D15);
		send_request(-17'sd2, 17'sd0, 5'd16, 4'd0, WS_D15);
		send_request(-17'sd127, -17'sd1, 5'd8, 4'd9, WS_D15);
		send_request(17'sd16383, 17'sd8000, 5'd14, 4'd3, WS_D7);
	endtask

	function automatic logic signed [16:0] pick_endpoint(input int p);
		int m;
		int v;
		if ($urandom_range(99) < 15)
			return 17'($urandom);
		m = cur_format ? (1 << (p - 1)) - 1 : (1 << p) - 1;
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(2))
				0: v = 0;
				1: v = m;
				default: v = m - 1;
			endcase
			if (cur_format && $urandom_range(1))
				v = -v;
		end else if (cur_format) begin
			v = int'($urandom_range(0, 2 * m)) - m;
		end else begin
			v = int'($urandom_range(0, m));
		end
		return 17'(v);
	endfunction

	task automatic send_random_texel();
		logic [4:0] p;
		logic [1:0] w;
		int         pe;
		p = ($urandom_range(99) < 85) ? 5'($urandom_range(2, 16)) : 5'($urandom_range(0, 31));
		pe = (p < 2) ? 2 : (p > 16) ? 16 : int'(p);
		w = ($urandom_range(99) < 90) ? 2'($urandom_range(0, 2)) : WS_SPARE;
		send_request(pick_endpoint(pe), pick_endpoint(pe), p, 4'($urandom_range(0, 15)), w);
	endtask

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_format(1'b0);
		run_directed();
		write_format(1'b1);
		run_directed();
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 68 : 0;
			recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 38 : 0;
			for (int fmt = 0; fmt < 2; fmt++) begin
				write_format(fmt[0]);
				repeat (RANDOM_PER_PHASE) send_random_texel();
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
